/* sv/ccsf_pkg.sv */
package ccsf_pkg;
	localparam int AREA_W = 42;
	localparam int LEN_W  = 37;
	localparam int CONV_W = 32;
	localparam int FORM_W = 48;
	localparam logic [32:0] SQRT2_Q32  = 33'd6074001000;
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

	// Snapshot of one finished contour, passed from front to back end.
	typedef struct packed {
		logic [AREA_W-1:0] area_x2;
		logic              empty;
		logic              hole;
		logic [24:0]       straight;
		logic [24:0]       diagonal;
		logic [27:0]       span;
	} ccsf_job_t;

	typedef struct packed {
		logic [AREA_W-1:0] area_x2;
		logic [LEN_W-1:0]  length_q16;
		logic [CONV_W-1:0] convexity_q16;
		logic [FORM_W-1:0] form_q16;
		logic              div_fault;
	} ccsf_res_t;
endpackage

/* sv/ccsf_front.sv */
module ccsf_front import ccsf_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int MAX_STEPS  = 1048576
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            first_item,
	input  logic            last_item,
	input  logic            has_step,
	input  logic [2:0]      dir_code,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic            is_hole,
	output logic            job_valid,
	input  logic            job_ready,
	output ccsf_job_t       job
);
	localparam int CW = COORD_BITS;
	localparam int SW = $clog2(MAX_STEPS + 1);

	logic signed [CW-1:0] px_q, py_q, xl_q, xh_q, yl_q, yh_q;
	logic signed [CW:0]   sl_q, sh_q, dl_q, dh_q;
	logic [SW-1:0]        st_q, dg_q;
	logic [AREA_W-1:0]    acc_q;
	logic                 hole_q;
	logic                 jv_q;
	ccsf_job_t            job_q;

	assign in_ready  = !jv_q || job_ready;
	assign job_valid = jv_q;
	assign job       = job_q;

	// post-first-item view
	logic signed [CW-1:0] bx, by, bxl, bxh, byl, byh, nx, ny;
	logic signed [CW:0]   bsl, bsh, bdl, bdh, ns, nd;
	logic [SW-1:0]        bst, bdg, nst, ndg;
	logic [AREA_W-1:0]    bacc, nacc, term;
	logic                 nhole;
	logic signed [CW-1:0] nxl, nxh, nyl, nyh;
	logic signed [CW:0]   nsl, nsh, ndl, ndh;
	logic [SW:0]          nsum;
	// extents are never negative; x and y ranges fit CW bits, sum and diff CW+1
	logic [CW-1:0]        xr, yr;
	logic [CW:0]          sr, dr;
	logic [CW+2:0]        span;

	always_comb begin
		bx = first_item ? CW'(start_x) : px_q;
		by = first_item ? CW'(start_y) : py_q;
		bxl = first_item ? bx : xl_q;  bxh = first_item ? bx : xh_q;
		byl = first_item ? by : yl_q;  byh = first_item ? by : yh_q;
		bsl = first_item ? {bx[CW-1], bx} + {by[CW-1], by} : sl_q;
		bsh = first_item ? {bx[CW-1], bx} + {by[CW-1], by} : sh_q;
		bdl = first_item ? {bx[CW-1], bx} - {by[CW-1], by} : dl_q;
		bdh = first_item ? {bx[CW-1], bx} - {by[CW-1], by} : dh_q;
		bst = first_item ? '0 : st_q;
		bdg = first_item ? '0 : dg_q;
		bacc = first_item ? '0 : acc_q;
		nhole = first_item ? is_hole : hole_q;
		nx = bx; ny = by; nxl = bxl; nxh = bxh; nyl = byl; nyh = byh;
		nsl = bsl; nsh = bsh; ndl = bdl; ndh = bdh; nst = bst; ndg = bdg;
		nacc = bacc; term = '0;
		ns = '0; nd = '0;
		if (has_step) begin
			case (dir_code)
				3'd0, 3'd1, 3'd7: nx = bx + CW'(1);
				3'd3, 3'd4, 3'd5: nx = bx - CW'(1);
				default: nx = bx;
			endcase
			case (dir_code)
				3'd1, 3'd2, 3'd3: ny = by + CW'(1);
				3'd5, 3'd6, 3'd7: ny = by - CW'(1);
				default: ny = by;
			endcase
			ns = {nx[CW-1], nx} + {ny[CW-1], ny};
			nd = {nx[CW-1], nx} - {ny[CW-1], ny};
			if (nx < nxl) nxl = nx;
			if (nx > nxh) nxh = nx;
			if (ny < nyl) nyl = ny;
			if (ny > nyh) nyh = ny;
			if (ns < nsl) nsl = ns;
			if (ns > nsh) nsh = ns;
			if (nd < ndl) ndl = nd;
			if (nd > ndh) ndh = nd;
			if (dir_code[0]) begin
				if (bdg < SW'(MAX_STEPS)) ndg = bdg + SW'(1);
			end else begin
				if (bst < SW'(MAX_STEPS)) nst = bst + SW'(1);
			end
			case (dir_code)
				3'd0: term = -AREA_W'(ny);
				3'd1: term = AREA_W'(nd);
				3'd2: term = AREA_W'(nx);
				3'd3: term = AREA_W'(ns);
				3'd4: term = AREA_W'(ny);
				3'd5: term = -AREA_W'(nd);
				3'd6: term = -AREA_W'(nx);
				default: term = -AREA_W'(ns);
			endcase
			nacc = bacc + term;
		end
		nsum = {1'b0, nst} + {1'b0, ndg};
		xr = nxh - nxl;
		yr = nyh - nyl;
		sr = nsh - nsl;
		dr = ndh - ndl;
		span = (CW+3)'(xr) + (CW+3)'(yr) + (CW+3)'(sr) + (CW+3)'(dr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0; py_q <= '0; xl_q <= '0; xh_q <= '0; yl_q <= '0; yh_q <= '0;
			sl_q <= '0; sh_q <= '0; dl_q <= '0; dh_q <= '0;
			st_q <= '0; dg_q <= '0; acc_q <= '0; hole_q <= 1'b0; jv_q <= 1'b0;
		end else begin
			if (job_ready) jv_q <= 1'b0;
			if (in_valid && in_ready) begin
				px_q <= nx; py_q <= ny; xl_q <= nxl; xh_q <= nxh; yl_q <= nyl; yh_q <= nyh;
				sl_q <= nsl; sh_q <= nsh; dl_q <= ndl; dh_q <= ndh;
				st_q <= nst; dg_q <= ndg; acc_q <= nacc; hole_q <= nhole;
				if (last_item) begin
					jv_q <= 1'b1;
					job_q.empty    <= (nsum == '0);
					job_q.hole     <= nhole;
					job_q.straight <= 25'(nst);
					job_q.diagonal <= 25'(ndg);
					job_q.span     <= 28'(span);
					if (nsum == '0) job_q.area_x2 <= AREA_W'(2);
					else job_q.area_x2 <= nacc + AREA_W'(nsum)
						+ (nhole ? -AREA_W'(2) : AREA_W'(2));
				end
			end
		end
	end
endmodule

/* sv/ccsf_back.sv */
module ccsf_back import ccsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  ccsf_job_t job,
	output logic      res_valid,
	input  logic      res_ready,
	output ccsf_res_t res
);
	typedef enum logic [2:0] {
		S_IDLE, S_LEN, S_SQ, S_SQ2, S_CDIV, S_FDIV, S_DONE
	} st_t;
	st_t st_q;
	ccsf_job_t j_q;
	logic [63:0] lenq32_q;
	logic [LEN_W-1:0] len_q;
	logic [CONV_W-1:0] conv_q;
	logic [FORM_W-1:0] form_q;
	logic fault_q;
	logic [127:0] num_q;
	logic [63:0]  den_q;
	logic [63:0]  rem_q;
	logic [6:0]   cnt_q;
	logic         over_q;
	logic [127:0] quo_q;
	logic [55:0]  sqlo_q;

	assign job_ready = (st_q == S_IDLE);
	assign res_valid = (st_q == S_DONE);
	assign res = '{area_x2: j_q.area_x2, length_q16: len_q, convexity_q16: conv_q,
		form_q16: form_q, div_fault: fault_q};

	logic [64:0] trial;
	logic [64:0] rsh;
	logic [63:0] lr;
	logic [63:0] fden;
	// length squared in two halves of the multiplier operand
	logic [55:0] sq_lo;
	logic [54:0] sq_hi;
	logic signed [AREA_W-1:0] a2s;
	always_comb begin
		rsh   = {rem_q, num_q[127]};
		trial = rsh - {1'b0, den_q};
		lr    = ((j_q.hole ? lenq32_q - 64'(SQRT2_Q32) * 64'd4 : lenq32_q)
			+ 64'd32768) >> 16;
		a2s   = j_q.area_x2;
		fden  = 64'(j_q.area_x2) * 64'(TWO_PI_Q16);
		sq_lo = 56'(len_q) * 56'(len_q[18:0]);
		sq_hi = 55'(len_q) * 55'(len_q[LEN_W-1:19]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: if (job_valid) begin
					j_q <= job; fault_q <= 1'b0; st_q <= S_LEN;
					lenq32_q <= ({39'd0, job.straight} << 32)
						+ 64'(job.diagonal) * 64'(SQRT2_Q32) + (64'd4 << 32);
				end
				S_LEN: begin
					if (j_q.empty) len_q <= LEN_W'(4) << 16;
					else if (j_q.hole && lenq32_q < 64'(SQRT2_Q32) * 64'd4) len_q <= '0;
					else len_q <= (lr > 64'((64'd1 << LEN_W) - 1)) ? '1 : LEN_W'(lr);
					if (j_q.empty) begin
						conv_q <= CONV_W'(1) << 16; st_q <= S_SQ;
					end else if (j_q.span == '0) begin
						conv_q <= '1; fault_q <= 1'b1; st_q <= S_SQ;
					end else begin
						den_q <= {35'd0, j_q.span, 1'b0};
						num_q <= {64'd0, ((64'(j_q.straight) * 3 + 64'(j_q.diagonal) * 4) << 16)
							+ 64'(j_q.span)};
						rem_q <= '0; cnt_q <= '0; over_q <= 1'b0; quo_q <= '0;
						st_q <= S_CDIV;
					end
				end
				S_CDIV, S_FDIV: begin
					num_q <= num_q << 1;
					if (!trial[64]) begin
						rem_q <= trial[63:0]; quo_q <= {quo_q[126:0], 1'b1};
						if (cnt_q < 7'd64) over_q <= 1'b1;
					end else begin
						rem_q <= rsh[63:0]; quo_q <= {quo_q[126:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						if (st_q == S_CDIV) begin
							conv_q <= (over_q || quo_q[62:31] != '0)
								? '1 : CONV_W'({quo_q[30:0], !trial[64]});
							st_q <= S_SQ;
						end else begin
							form_q <= (over_q || quo_q[62:47] != '0) ? '1
								: FORM_W'({quo_q[46:0], !trial[64]});
							st_q <= S_DONE;
						end
					end
				end
				S_SQ: begin
					if (a2s == '0) begin
						form_q <= '1; fault_q <= 1'b1; st_q <= S_DONE;
					end else if (a2s < 0) begin
						form_q <= '0; st_q <= S_DONE;
					end else begin
						den_q <= fden;
						sqlo_q <= sq_lo;
						st_q <= S_SQ2;
					end
				end
				S_SQ2: begin
					num_q <= (128'(sq_hi) << 19) + 128'(sqlo_q) + 128'(den_q >> 1);
					rem_q <= '0; cnt_q <= '0; over_q <= 1'b0; quo_q <= '0;
					st_q <= S_FDIV;
				end
				S_DONE: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/chain_code_shape_features_core.sv */
// Freeman chain code shape features. Codes enter on s_axis at one transfer
// per clock; the front end tracks position, extents, step counts and area.
// On the last code a contour snapshot goes into a one-entry handoff register
// and the back end, a bit-serial divider, makes length, convexity and form
// factor using up to two 128-step divisions.
// The front keeps accepting the next contour's codes meanwhile and stalls
// only when a second contour ends before the first result was taken.
module chain_code_shape_features_core import ccsf_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int MAX_STEPS  = 1048576
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: has_step, dir_code[2:0], start_x, start_y, is_hole (zero padded)
	input  logic [39:0]  s_axis_tdata,
	input  logic         s_axis_tlast,
	// tuser: first_item
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: area_x2, length_q16, convexity_q16, form_q16, div_fault
	output logic [159:0] m_axis_tdata
);
	logic      job_valid, job_ready;
	ccsf_job_t job;
	ccsf_res_t res;

	ccsf_front #(.COORD_BITS(COORD_BITS), .MAX_STEPS(MAX_STEPS)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.first_item(s_axis_tuser), .last_item(s_axis_tlast),
		.has_step(s_axis_tdata[0]), .dir_code(s_axis_tdata[3:1]),
		.start_x(s_axis_tdata[19:4]), .start_y(s_axis_tdata[35:20]),
		.is_hole(s_axis_tdata[36]),
		.job_valid, .job_ready, .job);

	ccsf_back u_back (.clk, .arst_n, .job_valid, .job_ready, .job,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res);

	assign m_axis_tdata = {res.div_fault, res.form_q16, res.convexity_q16,
		res.length_q16, res.area_x2};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !job_ready) else $error("back end busy mismatch");
endmodule
